// File: rtl/core/tws_pkg.sv
`timescale 1ns / 1ps
// Shared types, operation codes and decode helpers for the three-wire serial master.
// No dependencies; every other file of the block depends on this package.
package tws_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int HALF_STEPS = 4 * BYTE_BITS;
    localparam int STEP_W     = 6;
    localparam int SHIFT_W    = 2 * BYTE_BITS;
    localparam int VALUE_W    = 7;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic                 chip_enable;
        logic                 serial_clock;
        logic                 data_out;
        logic                 data_drive;
        logic                 busy_res;
        logic                 done_res;
        logic                 rejected;
        logic [BYTE_BITS-1:0] read_raw;
        logic [VALUE_W-1:0]   read_value;
    } t_result;

    // Two-digit BCD to binary: tens digit from bits 6..4, ones from bits 3..0.
    function automatic logic [VALUE_W-1:0] bcd_value(input logic [BYTE_BITS-1:0] raw);
        logic [VALUE_W-1:0] tens;
        logic [VALUE_W-1:0] ones;
        tens = {4'd0, raw[6:4]};
        ones = {3'd0, raw[3:0]};
        return (tens << 3) + (tens << 1) + ones;
    endfunction

endpackage

// File: rtl/core/tws_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result sides of the master.
// Depends on tws_pkg for widths.
interface tws_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic [tws_pkg::BYTE_BITS-1:0] command;
    logic [tws_pkg::BYTE_BITS-1:0] write_data;
    logic                          io_in;

    modport source (output valid, op, command, write_data, io_in, input ready);
    modport sink   (input valid, op, command, write_data, io_in, output ready);
endinterface

interface tws_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          chip_enable;
    logic                          serial_clock;
    logic                          data_out;
    logic                          data_drive;
    logic                          busy_res;
    logic                          done_res;
    logic                          rejected;
    logic [tws_pkg::BYTE_BITS-1:0] read_raw;
    logic [tws_pkg::VALUE_W-1:0]   read_value;

    modport source (output valid, chip_enable, serial_clock, data_out, data_drive, busy_res,
                    done_res, rejected, read_raw, read_value, input ready);
    modport sink   (input valid, chip_enable, serial_clock, data_out, data_drive, busy_res,
                    done_res, rejected, read_raw, read_value, output ready);
endinterface

// File: rtl/core/three_wire_rtc_serial_master.sv
`timescale 1ns / 1ps
// Top level of the three-wire serial clock-chip master: handshake and result register.
// Depends on tws_pkg, tws_if and tws_engine.
//
// Every request transaction yields exactly one result transaction, in the cycle after it is
// taken; a new request is taken in every cycle in which the result register is empty or
// its contents are being taken, so the block sustains one item per clock. A start (write
// or read) raises CE, and each tick then moves the pin waveform on by one half bit period:
// the command byte goes out LSB first with data set while SCLK is low, followed by the
// data byte of a write, or for a read by eight samples of the data line taken just before
// each rising SCLK edge and filled from the top bit. One more tick after the last bit
// drops CE with SCLK left high and flags done, so a transaction takes 33 ticks after its
// start. A start while a transaction runs is flagged as rejected and has no effect. The
// result shows the pin levels, busy, and the last read byte with its BCD value.
module three_wire_rtc_serial_master (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tws_req_if.sink   i_req,
    tws_rsp_if.source o_rsp
);
    import tws_pkg::*;

    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    accept;

    // take a new request whenever the result slot is empty or frees up this cycle
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    tws_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_req.op),
        .i_command    (i_req.command),
        .i_write_data (i_req.write_data),
        .i_io_in      (i_req.io_in),
        .o_result     (n_out)
    );

    // hold the result until the sink takes it; valid is control, payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.chip_enable  = r_out.chip_enable;
    assign o_rsp.serial_clock = r_out.serial_clock;
    assign o_rsp.data_out     = r_out.data_out;
    assign o_rsp.data_drive   = r_out.data_drive;
    assign o_rsp.busy_res     = r_out.busy_res;
    assign o_rsp.done_res     = r_out.done_res;
    assign o_rsp.rejected     = r_out.rejected;
    assign o_rsp.read_raw     = r_out.read_raw;
    assign o_rsp.read_value   = r_out.read_value;

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_rsp.valid)
        else $error("accepted request produced no result");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.done_res |-> !o_rsp.busy_res && !o_rsp.chip_enable)
        else $error("done flagged while transaction still open");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.rejected |-> o_rsp.busy_res && !o_rsp.done_res)
        else $error("start rejected while idle");
`endif

endmodule

// File: rtl/core/tws_engine.sv
`timescale 1ns / 1ps
// Transaction sequencer: pin state, half-step counter and shift registers.
// Depends on tws_pkg; updates state on each accepted item and presents its result.
module tws_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_op,
    input  logic [tws_pkg::BYTE_BITS-1:0] i_command,
    input  logic [tws_pkg::BYTE_BITS-1:0] i_write_data,
    input  logic                          i_io_in,
    output tws_pkg::t_result              o_result
);
    import tws_pkg::*;

    logic                 r_active,       n_active;
    logic                 r_reading,      n_reading;
    logic [STEP_W-1:0]    r_step_count,   n_step_count;
    logic [SHIFT_W-1:0]   r_out_shift,    n_out_shift;
    logic [BYTE_BITS-1:0] r_in_shift,     n_in_shift;
    logic                 r_clock_level,  n_clock_level;
    logic                 r_enable_level, n_enable_level;
    logic                 done;
    logic                 rej;
    logic                 listen;

    always_comb begin
        n_active       = r_active;
        n_reading      = r_reading;
        n_step_count   = r_step_count;
        n_out_shift    = r_out_shift;
        n_in_shift     = r_in_shift;
        n_clock_level  = r_clock_level;
        n_enable_level = r_enable_level;
        done           = 1'b0;
        rej            = 1'b0;
        unique case (i_op)
            OP_WRITE, OP_READ: begin
                if (r_active) begin
                    rej = 1'b1;
                end else begin
                    n_active       = 1'b1;
                    n_reading      = (i_op == OP_READ);
                    n_step_count   = '0;
                    n_clock_level  = 1'b0;
                    n_enable_level = 1'b1;
                    if (i_op == OP_READ) begin
                        n_out_shift = {{(SHIFT_W-BYTE_BITS){1'b0}}, i_command};
                        n_in_shift  = '0;
                    end else begin
                        n_out_shift = {i_write_data, i_command};
                    end
                end
            end
            OP_TICK: begin
                if (r_active) begin
                    if (r_step_count >= STEP_W'(HALF_STEPS)) begin
                        // last half step: drop CE, leave SCLK high
                        n_enable_level = 1'b0;
                        n_active       = 1'b0;
                        n_step_count   = '0;
                        done           = 1'b1;
                    end else begin
                        if (!r_step_count[0]) begin
                            n_clock_level = 1'b0;
                            if (r_step_count[STEP_W-1:1] != '0) begin
                                n_out_shift = r_out_shift >> 1;
                            end
                        end else begin
                            // sample while SCLK is still low, then raise it
                            if (r_reading && r_step_count >= STEP_W'(2 * BYTE_BITS)) begin
                                n_in_shift = {i_io_in, r_in_shift[BYTE_BITS-1:1]};
                            end
                            n_clock_level = 1'b1;
                        end
                        n_step_count = r_step_count + STEP_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // line is released once the first data bit of a read is due
    assign listen = n_reading && (n_step_count >= STEP_W'(2 * BYTE_BITS + 1));

    always_comb begin
        o_result              = '0;
        o_result.chip_enable  = n_enable_level;
        o_result.serial_clock = n_clock_level;
        o_result.data_drive   = n_active && !listen;
        o_result.data_out     = n_active && !listen && n_out_shift[0];
        o_result.busy_res     = n_active;
        o_result.done_res     = done;
        o_result.rejected     = rej;
        o_result.read_raw     = n_in_shift;
        o_result.read_value   = bcd_value(n_in_shift);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_reading      <= 1'b0;
            r_step_count   <= '0;
            r_out_shift    <= '0;
            r_in_shift     <= '0;
            r_clock_level  <= 1'b0;
            r_enable_level <= 1'b0;
        end else if (i_accept) begin
            r_active       <= n_active;
            r_reading      <= n_reading;
            r_step_count   <= n_step_count;
            r_out_shift    <= n_out_shift;
            r_in_shift     <= n_in_shift;
            r_clock_level  <= n_clock_level;
            r_enable_level <= n_enable_level;
        end
    end

`ifndef SYNTHESIS
    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_step_count == '0)
        else $error("step counter nonzero while idle");

    a_idle_ce_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> !r_enable_level)
        else $error("CE high while idle");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step_count <= STEP_W'(HALF_STEPS))
        else $error("step counter past end of transaction");

    a_end_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_op == OP_TICK && r_active && r_step_count == STEP_W'(HALF_STEPS)
        |=> !r_active && r_clock_level)
        else $error("transaction did not close with SCLK high");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the three-wire serial clock-chip master: random write/read
// transactions, rejected starts and idle traffic, checked against an in-bench predictor.
// Depends on tws_pkg, tws_if and three_wire_rtc_serial_master.
module tb;
    import tws_pkg::*;

    // Op code three carries no meaning for the block and must be a no-op.
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int WORK_GOAL = 1950;
    // Eight samples land on the ticks that raise SCLK in the second byte.
    localparam int FIRST_SAMPLE_TICK = 18;
    localparam int TICKS_PER_TRANSACTION = HALF_STEPS + 1;

    typedef struct {
        logic [1:0]           op;
        logic [BYTE_BITS-1:0] command;
        logic [BYTE_BITS-1:0] write_data;
        logic                 io_in;
    } t_serial_req;

    logic clk;
    logic rst_n;

    tws_req_if req ();
    tws_rsp_if rsp ();

    three_wire_rtc_serial_master DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    t_serial_req pending_reqs[$];
    t_result     expected_results[$];

    // Pin-level state of the master as the bench sees it.
    logic                 busy_q      = 1'b0;
    logic                 read_mode_q = 1'b0;
    logic [STEP_W-1:0]    half_step_q = '0;
    logic [SHIFT_W-1:0]   tx_shift_q  = '0;
    logic [BYTE_BITS-1:0] rx_byte_q   = '0;
    logic                 sclk_q      = 1'b0;
    logic                 ce_q        = 1'b0;

    int          work_items   = 0;
    int          results_seen = 0;
    int          error_count  = 0;
    int          cycle_count  = 0;
    int          send_gap     = 0;
    int          send_calm    = 0;
    int          recv_gap     = 0;
    int          recv_calm    = 0;
    logic        req_taken    = 1'b0;
    logic        rsp_taken    = 1'b0;
    logic        long_hold    = 1'b0;
    t_serial_req next_req;
    t_serial_req taken_req;
    t_result     observed;
    t_result     wanted;

    // Apply one request transaction to the pin state and return the result it should give.
    function automatic t_result predict_pins(t_serial_req it);
        t_result           r;
        logic [STEP_W-1:0] s;
        logic [STEP_W-1:0] bit_idx;
        logic              done;
        logic              rej;
        done = 1'b0;
        rej  = 1'b0;
        if (it.op == OP_WRITE || it.op == OP_READ) begin
            if (busy_q) begin
                rej = 1'b1;
            end else begin
                busy_q      = 1'b1;
                read_mode_q = (it.op == OP_READ);
                half_step_q = '0;
                sclk_q      = 1'b0;
                ce_q        = 1'b1;
                if (read_mode_q) begin
                    tx_shift_q = {{BYTE_BITS{1'b0}}, it.command};
                    rx_byte_q  = '0;
                end else begin
                    tx_shift_q = {it.write_data, it.command};
                end
            end
        end else if (it.op == OP_TICK && busy_q) begin
            s = half_step_q;
            if (s >= HALF_STEPS) begin
                // Closing tick: SCLK stays high, CE drops.
                ce_q        = 1'b0;
                busy_q      = 1'b0;
                half_step_q = '0;
                done        = 1'b1;
            end else begin
                if (!s[0]) begin
                    sclk_q = 1'b0;
                    if (s[STEP_W-1:1] != 0) tx_shift_q = tx_shift_q >> 1;
                end else begin
                    // Sample while SCLK is still low, then raise it.
                    if (read_mode_q && s[STEP_W-1:1] >= BYTE_BITS)
                        rx_byte_q = {it.io_in, rx_byte_q[BYTE_BITS-1:1]};
                    sclk_q = 1'b1;
                end
                half_step_q = s + 1'b1;
            end
        end
        bit_idx = (half_step_q == '0) ? '0 : (half_step_q - 1'b1) >> 1;
        r.chip_enable  = ce_q;
        r.serial_clock = sclk_q;
        r.data_drive   = busy_q && !(read_mode_q && bit_idx >= BYTE_BITS);
        r.data_out     = r.data_drive & tx_shift_q[0];
        r.busy_res     = busy_q;
        r.done_res     = done;
        r.rejected     = rej;
        r.read_raw     = rx_byte_q;
        r.read_value   = VALUE_W'(rx_byte_q[6:4]) * 7'd10 + VALUE_W'(rx_byte_q[3:0]);
        return r;
    endfunction

    task automatic add_item(input logic [1:0] op, input logic [7:0] cmd,
                            input logic [7:0] wdat, input logic io);
        t_serial_req it;
        it.op         = op;
        it.command    = cmd;
        it.write_data = wdat;
        it.io_in      = io;
        pending_reqs.push_back(it);
    endtask

    // One start and its full run of ticks; the line level follows rx_byte on sample ticks.
    // With mark_busy set, a rejected write, a rejected read and a no-op fall mid-way.
    task automatic queue_transaction(input logic [1:0] op, input logic [7:0] cmd,
                                     input logic [7:0] wdat, input logic [7:0] rx_byte,
                                     input logic mark_busy, input int noise_pct);
        int   i;
        logic io;
        add_item(op, cmd, wdat, 1'($urandom_range(0, 1)));
        work_items++;
        for (i = 1; i <= TICKS_PER_TRANSACTION; i++) begin
            if (mark_busy && i == 4) begin
                add_item(OP_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
                work_items++;
            end else if (mark_busy && i == 12) begin
                add_item(OP_READ, 8'($urandom), 8'($urandom), 1'($urandom));
                work_items++;
            end else if (mark_busy && i == 20) begin
                add_item(OP_NONE, 8'($urandom), 8'($urandom), 1'($urandom));
                work_items++;
            end else if ($urandom_range(0, 99) < noise_pct) begin
                case ($urandom_range(0, 2))
                    0: add_item(OP_NONE, 8'($urandom), 8'($urandom), 1'($urandom));
                    1: add_item(OP_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
                    default: add_item(OP_READ, 8'($urandom), 8'($urandom), 1'($urandom));
                endcase
                work_items++;
            end
            if (i % 2 == 0 && i >= FIRST_SAMPLE_TICK && i < TICKS_PER_TRANSACTION)
                io = rx_byte[(i - FIRST_SAMPLE_TICK) / 2];
            else
                io = 1'($urandom_range(0, 1));
            add_item(OP_TICK, 8'($urandom), 8'($urandom), io);
            work_items++;
        end
    endtask

    // Mostly back-to-back or short gaps, a few long ones, and now and then a calm stretch.
    task automatic draw_gap(inout int calm, output int gap);
        int roll;
        roll = $urandom_range(0, 999);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else if (roll < 5) begin
            calm = $urandom_range(50, 200);
            gap  = 0;
        end else if (roll < 550) begin
            gap = 0;
        end else if (roll < 930) begin
            gap = $urandom_range(1, 3);
        end else if (roll < 985) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 40);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample both channels; record acceptance for the drivers, predict and check.
    always @(posedge clk) begin
        req_taken = rst_n && req.valid && req.ready;
        rsp_taken = rst_n && rsp.valid && rsp.ready;
        if (req_taken) begin
            taken_req.op         = req.op;
            taken_req.command    = req.command;
            taken_req.write_data = req.write_data;
            taken_req.io_in      = req.io_in;
            expected_results.push_back(predict_pins(taken_req));
        end
        if (rsp_taken) begin
            results_seen++;
            observed.chip_enable  = rsp.chip_enable;
            observed.serial_clock = rsp.serial_clock;
            observed.data_out     = rsp.data_out;
            observed.data_drive   = rsp.data_drive;
            observed.busy_res     = rsp.busy_res;
            observed.done_res     = rsp.done_res;
            observed.rejected     = rsp.rejected;
            observed.read_raw     = rsp.read_raw;
            observed.read_value   = rsp.read_value;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("result %0d arrived with nothing expected", results_seen);
            end else begin
                wanted = expected_results.pop_front();
                if (observed.chip_enable  !== wanted.chip_enable  ||
                    observed.serial_clock !== wanted.serial_clock ||
                    observed.data_out     !== wanted.data_out     ||
                    observed.data_drive   !== wanted.data_drive   ||
                    observed.busy_res     !== wanted.busy_res     ||
                    observed.done_res     !== wanted.done_res     ||
                    observed.rejected     !== wanted.rejected     ||
                    observed.read_raw     !== wanted.read_raw     ||
                    observed.read_value   !== wanted.read_value) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("result %0d mismatch", results_seen);
                        $display("  expected ce=%b sclk=%b dout=%b drv=%b busy=%b done=%b",
                                 wanted.chip_enable, wanted.serial_clock, wanted.data_out,
                                 wanted.data_drive, wanted.busy_res, wanted.done_res);
                        $display("           rej=%b raw=%h val=%0d",
                                 wanted.rejected, wanted.read_raw, wanted.read_value);
                        $display("  actual   ce=%b sclk=%b dout=%b drv=%b busy=%b done=%b",
                                 observed.chip_enable, observed.serial_clock,
                                 observed.data_out, observed.data_drive,
                                 observed.busy_res, observed.done_res);
                        $display("           rej=%b raw=%h val=%0d",
                                 observed.rejected, observed.read_raw, observed.read_value);
                    end
                end
            end
        end
    end

    // Request driver: hold an item until taken, then idle for a drawn gap.
    always @(negedge clk) begin
        if (rst_n && (!req.valid || req_taken)) begin
            if (send_gap > 0 || pending_reqs.size() == 0) begin
                req.valid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end else begin
                next_req = pending_reqs.pop_front();
                req.valid      <= 1'b1;
                req.op         <= next_req.op;
                req.command    <= next_req.command;
                req.write_data <= next_req.write_data;
                req.io_in      <= next_req.io_in;
                draw_gap(send_calm, send_gap);
            end
        end
    end

    // Result receiver: random stalls after each transaction, plus the long hold-off.
    always @(negedge clk) begin
        if (rst_n) begin
            if (rsp_taken) draw_gap(recv_calm, recv_gap);
            if (long_hold || recv_gap > 0) begin
                rsp.ready <= 1'b0;
                if (recv_gap > 0) recv_gap--;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Starve the result side long enough for the block to back up onto its input.
    initial begin
        wait (results_seen >= 300);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("three_wire_rtc_serial_master test failed");
            $finish;
        end
    end

    initial begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.op         = OP_TICK;
        req.command    = '0;
        req.write_data = '0;
        req.io_in      = 1'b0;
        rsp.ready      = 1'b0;

        // Idle traffic: ticks and no-ops must leave the pins at rest.
        add_item(OP_TICK, 8'h00, 8'h00, 1'b0);
        add_item(OP_TICK, 8'hff, 8'hff, 1'b1);
        add_item(OP_NONE, 8'hff, 8'hff, 1'b1);
        // Extreme bytes both ways, the first with starts arriving mid-transaction.
        queue_transaction(OP_WRITE, 8'hff, 8'h00, 8'h00, 1'b1, 0);
        queue_transaction(OP_WRITE, 8'h00, 8'hff, 8'hff, 1'b0, 0);
        // All-ones read gives the largest non-BCD value; then the largest BCD byte.
        queue_transaction(OP_READ, 8'h00, 8'h00, 8'hff, 1'b1, 0);
        queue_transaction(OP_READ, 8'h81, 8'h00, 8'h79, 1'b0, 0);
        add_item(OP_TICK, 8'h5a, 8'ha5, 1'b1);

        // Mostly well-formed transactions with random content, some idle noise between.
        while (work_items < WORK_GOAL) begin
            if ($urandom_range(0, 99) < 85) begin
                queue_transaction($urandom_range(0, 1) ? OP_READ : OP_WRITE,
                                  8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 4);
            end else begin
                repeat ($urandom_range(1, 4))
                    add_item($urandom_range(0, 3) == 0 ? OP_NONE : OP_TICK,
                             8'($urandom), 8'($urandom), 1'($urandom));
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req.valid) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("three_wire_rtc_serial_master test passed");
        end else begin
            $display("three_wire_rtc_serial_master test failed");
        end
        $finish;
    end

endmodule
